[sv/clhl_pkg.sv]
// ----------------------------------------------------------------------------
// COBOL highlight lexer package
// Shared types, token class codes, lexer states and the keyword table.
// ----------------------------------------------------------------------------
package clhl_pkg;

	// Fixed widths of the result fields.
	localparam int unsigned CLASS_W      = 4;
	localparam int unsigned START_W      = 24;
	localparam int unsigned LENGTH_OUT_W = 16;

	// Defaults for the internal counter widths.
	localparam int unsigned POS_W_DEF = 24;
	localparam int unsigned LEN_W_DEF = 16;

	// Depth of the queue between the front end and the result stage.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Token classes as they appear on the result port.
	typedef enum logic [CLASS_W-1:0] {
		CLS_SPACE    = 4'd0,
		CLS_NEWLINE  = 4'd1,
		CLS_TAB      = 4'd2,
		CLS_STRING   = 4'd3,
		CLS_COMMENT  = 4'd4,
		CLS_BRACKET  = 4'd5,
		CLS_OPERATOR = 4'd6,
		CLS_NUMBER   = 4'd7,
		CLS_KEYWORD  = 4'd8,
		CLS_VARIABLE = 4'd9
	} token_class_t;

	// Kind of the token that is still open in the front end.
	typedef enum logic [2:0] {
		PK_NONE    = 3'd0,
		PK_STRING  = 3'd1,
		PK_COMMENT = 3'd2,
		PK_NUMBER  = 3'd3,
		PK_WORD    = 3'd4,
		PK_EQ      = 3'd5,
		PK_PLUS    = 3'd6,
		PK_MINUS   = 3'd7
	} pend_kind_t;

	// One finished token.
	typedef struct packed {
		token_class_t              cls;
		logic [START_W-1:0]        start;
		logic [LENGTH_OUT_W-1:0]   len;
	} token_rec_t;

	// All tokens finished by one input byte: one or two of them.
	typedef struct packed {
		token_rec_t rec0;
		token_rec_t rec1;
		logic       two;
	} token_entry_t;

	// Keyword table, right-justified text with its length alongside.
	localparam int unsigned NKW        = 44;
	localparam int unsigned KW_MAX_LEN = 14;
	localparam int unsigned KW_IDX_W   = $clog2(KW_MAX_LEN);
	localparam int unsigned KW_TEXT_W  = 8 * KW_MAX_LEN;

	localparam logic [KW_TEXT_W-1:0] KW_TEXT [NKW] = '{
		"IDENTIFICATION", "DIVISION", "PROGRAM", "ENVIRONMENT", "SELECT",
		"ASSIGN", "FD", "SD", "FILE", "DATA", "SECTION", "PROCEDURE",
		"DECLARATIVES", "IF", "THEN", "ELSE", "ENDIF", "PERFORM", "VARYING",
		"FROM", "TO", "BY", "TIMES", "WHILE", "GO", "MOVE", "ADD", "SUBTRACT",
		"MULTIPLY", "DIVIDE", "COMPUTE", "SET", "RESET", "ACCEPT", "DISPLAY",
		"CALL", "RETURN", "STOP", "END", "TRUE", "FALSE", "ZERO", "SPACE", "NULL"
	};

	localparam int unsigned KW_LEN [NKW] = '{
		14, 8, 7, 11, 6,
		6, 2, 2, 4, 4, 7, 9,
		12, 2, 4, 4, 5, 7, 7,
		4, 2, 2, 5, 5, 2, 4, 3, 8,
		8, 6, 7, 3, 5, 6, 7,
		4, 6, 4, 3, 4, 5, 4, 5, 4
	};

	// Character j of keyword k, counted from its first letter; zero past its end.
	function automatic logic [7:0] kw_char(input int unsigned k,
			input logic [KW_IDX_W-1:0] j);
		logic [KW_TEXT_W-1:0] txt;
		int unsigned          l;
		int unsigned          jj;
		txt = KW_TEXT[k];
		l   = KW_LEN[k];
		jj  = 32'(j);
		if (jj < l) begin
			return txt[8*(l-1-jj) +: 8];
		end
		return 8'h00;
	endfunction

endpackage

[sv/cobol_highlight_lexer_top.sv]
// ----------------------------------------------------------------------------
// COBOL highlight lexer
// Splits a byte stream of COBOL source into highlighting tokens.
// ----------------------------------------------------------------------------
// Input channel: a byte transfers on a clock edge with push high and full
// low. With end_of_text high the byte is ignored; the open token is flushed
// and the position counter returns to zero.
// Result channel: while empty is low the oldest token sits on token_class,
// token_start and token_length; it transfers on an edge with pop high.
// last_of_run marks the final token caused by one input transfer.
// A byte can finish up to two tokens: the one it closes and a one-byte token
// of its own.
// Throughput: one byte per cycle while full is low. The front end classifies
// a byte in the cycle it is taken and writes its tokens into a four-entry
// queue; the result stage then drains one token per cycle while pop
// is high, so a byte that finishes two tokens presents them in turn.
// With the result stage idle, the tokens of a byte are written into the
// queue when the byte transfers and then loaded into the output register.
// Reset clears the lexer state, the queue and the output register.
// When the receiver stalls the queue fills and full rises; no token is lost.
// ----------------------------------------------------------------------------
module cobol_highlight_lexer_top import clhl_pkg::*; #(
	parameter int unsigned POSITION_WIDTH = POS_W_DEF,
	parameter int unsigned LENGTH_WIDTH   = LEN_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [7:0]               ch,
	input  logic                     end_of_text,
	output logic                     empty,
	input  logic                     pop,
	output logic [CLASS_W-1:0]       token_class,
	output logic [START_W-1:0]       token_start,
	output logic [LENGTH_OUT_W-1:0]  token_length,
	output logic                     last_of_run
);

	logic         take;
	logic         entry_valid;
	token_entry_t entry;
	logic         q_valid;
	logic         q_pop;
	token_entry_t q_data;

	assign take = push && !full;

	// Front end: classification and token tracking.
	clhl_front #(
		.POSITION_WIDTH (POSITION_WIDTH),
		.LENGTH_WIDTH   (LENGTH_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.ch          (ch),
		.end_of_text (end_of_text),
		.entry_valid (entry_valid),
		.entry       (entry)
	);

	// Queue between the two halves.
	clhl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (entry_valid),
		.wr_data  (entry),
		.full     (full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	// Result stage.
	clhl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.token_class  (token_class),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule

[sv/clhl_front.sv]
// ----------------------------------------------------------------------------
// COBOL highlight lexer front end
// Classifies each accepted byte, tracks the open token and the keyword
// candidates, and hands the finished tokens of the byte to the queue.
// ----------------------------------------------------------------------------
module clhl_front import clhl_pkg::*; #(
	parameter int unsigned POSITION_WIDTH = POS_W_DEF,
	parameter int unsigned LENGTH_WIDTH   = LEN_W_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   ch,
	input  logic         end_of_text,
	output logic         entry_valid,
	output token_entry_t entry
);

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = LENGTH_WIDTH'(1);

	pend_kind_t                 kind_q, kind_d;
	logic                       single_q, single_d;
	logic [POSITION_WIDTH-1:0]  pos_q, pos_d;
	logic [POSITION_WIDTH-1:0]  start_q, start_d;
	logic [LENGTH_WIDTH-1:0]    len_q, len_d;
	logic [NKW-1:0]             match_q, match_d;

	logic                       is_digit, is_alpha, is_word_ch;
	logic [LENGTH_WIDTH-1:0]    grown;
	logic                       kw_hit;
	token_class_t               pend_cls;
	logic                       restart;
	logic                       em_a, em_b;
	token_class_t               cls_a, cls_b;
	logic [POSITION_WIDTH-1:0]  start_a, start_b;
	logic [LENGTH_WIDTH-1:0]    len_a, len_b;
	logic [NKW-1:0]             first_eq, next_eq, len_eq;

	// Character classes, ASCII only.
	assign is_digit   = ch inside {[CH_0:CH_9]};
	assign is_alpha   = (ch inside {[CH_UA:CH_UZ]}) || (ch inside {[CH_LA:CH_LZ]});
	assign is_word_ch = is_alpha || is_digit || (ch == CH_USCORE);

	// Saturating length increment.
	assign grown = (len_q == '1) ? len_q : len_q + LEN_ONE;

	// Keyword candidates: compare this byte against every keyword at once.
	always_comb begin
		for (int unsigned k = 0; k < NKW; k++) begin
			first_eq[k] = (kw_char(k, '0) == ch);
			next_eq[k]  = (len_q < LENGTH_WIDTH'(KW_MAX_LEN)) &&
				(kw_char(k, len_q[KW_IDX_W-1:0]) == ch);
			len_eq[k]   = (len_q == LENGTH_WIDTH'(KW_LEN[k]));
		end
	end

	// A word is a keyword when a candidate still matches at its exact length.
	assign kw_hit = |(match_q & len_eq);

	// Class of the open token when it is closed by a byte it does not take.
	always_comb begin
		case (kind_q)
			PK_STRING:  pend_cls = CLS_STRING;
			PK_COMMENT: pend_cls = CLS_COMMENT;
			PK_NUMBER:  pend_cls = CLS_NUMBER;
			PK_WORD:    pend_cls = kw_hit ? CLS_KEYWORD : CLS_VARIABLE;
			PK_EQ:      pend_cls = CLS_VARIABLE;
			default:    pend_cls = CLS_OPERATOR;
		endcase
	end

	// Lexer step for one accepted item.
	always_comb begin
		kind_d   = kind_q;
		single_d = single_q;
		pos_d    = pos_q;
		start_d  = start_q;
		len_d    = len_q;
		match_d  = match_q;
		restart  = 1'b1;
		em_a     = 1'b0;
		cls_a    = pend_cls;
		start_a  = start_q;
		len_a    = len_q;
		em_b     = 1'b0;
		cls_b    = CLS_VARIABLE;
		start_b  = pos_q;
		len_b    = LEN_ONE;

		if (take && end_of_text) begin
			// End of text flushes the open token and rewinds the position.
			em_a   = (kind_q != PK_NONE);
			kind_d = PK_NONE;
			pos_d  = '0;
		end else if (take) begin
			pos_d = pos_q + POSITION_WIDTH'(1);

			// Try to extend or close the open token.
			case (kind_q)
				PK_STRING: begin
					len_d   = grown;
					restart = 1'b0;
					if (ch == (single_q ? CH_SQUOTE : CH_DQUOTE)) begin
						em_a   = 1'b1;
						cls_a  = CLS_STRING;
						len_a  = grown;
						kind_d = PK_NONE;
					end
				end
				PK_COMMENT: begin
					if (ch != CH_NL) begin
						len_d   = grown;
						restart = 1'b0;
					end
				end
				PK_NUMBER: begin
					if (is_digit || (ch == CH_DOT)) begin
						len_d   = grown;
						restart = 1'b0;
					end
				end
				PK_WORD: begin
					if (is_word_ch) begin
						len_d   = grown;
						match_d = match_q & next_eq;
						restart = 1'b0;
					end
				end
				PK_EQ, PK_PLUS, PK_MINUS: begin
					if (ch == CH_EQ) begin
						em_a    = 1'b1;
						cls_a   = CLS_OPERATOR;
						len_a   = grown;
						kind_d  = PK_NONE;
						restart = 1'b0;
					end
				end
				default: begin
				end
			endcase

			// Close the open token and start afresh with this byte.
			if (restart) begin
				em_a   = (kind_q != PK_NONE);
				kind_d = PK_NONE;
				if (ch == CH_SPACE) begin
					em_b  = 1'b1;
					cls_b = CLS_SPACE;
				end else if (ch == CH_NL) begin
					em_b  = 1'b1;
					cls_b = CLS_NEWLINE;
				end else if (ch == CH_TAB) begin
					em_b  = 1'b1;
					cls_b = CLS_TAB;
				end else if (ch inside {CH_DQUOTE, CH_SQUOTE}) begin
					kind_d   = PK_STRING;
					single_d = (ch == CH_SQUOTE);
				end else if (ch inside {CH_STAR, CH_SLASH}) begin
					kind_d = PK_COMMENT;
				end else if (ch inside {CH_LBRACE, CH_RBRACE, CH_LBRK, CH_RBRK,
						CH_LPAR, CH_RPAR}) begin
					em_b  = 1'b1;
					cls_b = CLS_BRACKET;
				end else if (ch == CH_EQ) begin
					kind_d = PK_EQ;
				end else if (ch == CH_PLUS) begin
					kind_d = PK_PLUS;
				end else if (ch == CH_MINUS) begin
					kind_d = PK_MINUS;
				end else if (ch inside {CH_LT, CH_GT, CH_AMP, CH_BAR, CH_CARET,
						CH_TILDE, CH_BANG}) begin
					em_b  = 1'b1;
					cls_b = CLS_OPERATOR;
				end else if (is_digit) begin
					kind_d = PK_NUMBER;
				end else if (is_alpha || (ch == CH_USCORE)) begin
					kind_d  = PK_WORD;
					match_d = first_eq;
				end else begin
					em_b  = 1'b1;
					cls_b = CLS_VARIABLE;
				end
				// A new open token starts at this byte.
				if (kind_d != PK_NONE) begin
					start_d = pos_q;
					len_d   = LEN_ONE;
				end
			end
		end
	end

	// Pack the tokens of this byte, oldest first.
	always_comb begin
		entry_valid     = em_a || em_b;
		entry.two       = em_a && em_b;
		entry.rec1.cls  = cls_b;
		entry.rec1.start = START_W'(start_b);
		entry.rec1.len  = LENGTH_OUT_W'(len_b);
		if (em_a) begin
			entry.rec0.cls   = cls_a;
			entry.rec0.start = START_W'(start_a);
			entry.rec0.len   = LENGTH_OUT_W'(len_a);
		end else begin
			entry.rec0 = entry.rec1;
		end
	end

	// Lexer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= PK_NONE;
			single_q <= 1'b0;
			pos_q    <= '0;
		end else begin
			kind_q   <= kind_d;
			single_q <= single_d;
			pos_q    <= pos_d;
		end
	end

	// Open token payload.
	always_ff @(posedge clk) begin
		start_q <= start_d;
		len_q   <= len_d;
		match_q <= match_d;
	end

endmodule

[sv/clhl_queue.sv]
// ----------------------------------------------------------------------------
// COBOL highlight lexer token queue
// Short first-in first-out buffer of token entries between the front end
// and the result stage.
// ----------------------------------------------------------------------------
module clhl_queue import clhl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  token_entry_t wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic         rd_valid,
	output token_entry_t rd_data
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = PTR_W + 1;

	token_entry_t       slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr, do_rd;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[sv/clhl_back.sv]
// ----------------------------------------------------------------------------
// COBOL highlight lexer result stage
// Holds the entry at the head of the queue in an output register and
// presents its tokens one transfer at a time.
// ----------------------------------------------------------------------------
module clhl_back import clhl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  token_entry_t             q_data,
	output logic                     q_pop,
	output logic                     empty,
	input  logic                     pop,
	output logic [CLASS_W-1:0]       token_class,
	output logic [START_W-1:0]       token_start,
	output logic [LENGTH_OUT_W-1:0]  token_length,
	output logic                     last_of_run
);

	token_entry_t cur_q;
	logic         valid_q;
	logic         idx_q;
	logic         xfer;
	logic         last;
	token_rec_t   rec;

	assign empty  = !valid_q;
	assign xfer   = pop && valid_q;
	assign last   = !cur_q.two || idx_q;
	assign q_pop  = !valid_q || (xfer && last);

	// Current token of the held entry.
	assign rec          = idx_q ? cur_q.rec1 : cur_q.rec0;
	assign token_class  = rec.cls;
	assign token_start  = rec.start;
	assign token_length = rec.len;
	assign last_of_run  = last;

	// Output register control: step within the entry or load the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (q_pop) begin
			valid_q <= q_valid;
			idx_q   <= 1'b0;
		end else if (xfer) begin
			idx_q <= 1'b1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

endmodule

[sv/clhl_checker.sv]
// ----------------------------------------------------------------------------
// COBOL highlight lexer port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module clhl_checker import clhl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     full,
	input  logic                     empty,
	input  logic                     pop,
	input  logic [CLASS_W-1:0]       token_class,
	input  logic [START_W-1:0]       token_start,
	input  logic [LENGTH_OUT_W-1:0]  token_length,
	input  logic                     last_of_run
);

	// While reset is held the block has nothing to offer and takes input freely.
	assert property (@(posedge clk) !arst_n |-> empty && !full)
	else $error("result waiting or input blocked during reset");

	// A token that is not the last of its byte is followed at once by its companion.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last_of_run |=> !empty)
	else $error("companion token missing after a non-final transfer");

	// No byte finishes more than two tokens, so the companion is always final.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last_of_run |=> last_of_run)
	else $error("more than two tokens for one byte");

	// A waiting token holds while the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(token_class) && $stable(token_start) &&
			$stable(token_length) && $stable(last_of_run))
	else $error("waiting token changed under a stall");

	// Every presented token has a valid class and a non-zero length.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> token_length != '0 && token_class <= CLS_VARIABLE)
	else $error("malformed token on the result port");

endmodule

bind cobol_highlight_lexer_top clhl_checker u_checker (.*);

[sim/tb_cobol_highlight_lexer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the COBOL highlight lexer
// Drives source bytes and end-of-text items into the lexer and checks every
// token against a cycle-free model of the tokeniser kept in a scoreboard.
// Random gaps on both channels, overlong words and strings, and a random run
// of well-formed COBOL-like text with noise mixed in.
// ----------------------------------------------------------------------------
module tb_cobol_highlight_lexer_top;
	import clhl_pkg::*;

	// One expected token as it should appear on the result ports.
	typedef struct {
		token_class_t      cls;
		logic [START_W-1:0] start;
		logic [LENGTH_OUT_W-1:0] len;
		logic              last;
	} lex_token_t;

	// Tokeniser model plus the queue of tokens still to arrive.
	class token_scoreboard;
		lex_token_t  awaited[$];
		lex_token_t  new_tokens[$];
		int unsigned failures;
		pend_kind_t  open_kind;
		logic        quote_single;
		logic [23:0] open_start;
		logic [15:0] open_len;
		logic [23:0] position;
		logic [7:0]  word_buf [14];
		logic        word_ovf;

		function new();
			open_kind    = PK_NONE;
			quote_single = 1'b0;
			open_start   = '0;
			open_len     = '0;
			position     = '0;
			word_ovf     = 1'b0;
			failures     = 0;
			foreach (word_buf[i]) word_buf[i] = 8'h00;
		endfunction

		function void emit_token(token_class_t c, logic [23:0] s, logic [15:0] l);
			lex_token_t t;
			t.cls   = c;
			t.start = s;
			t.len   = l;
			t.last  = 1'b0;
			new_tokens.push_back(t);
		endfunction

		function logic [15:0] grown(logic [15:0] l);
			return (l != 16'hFFFF) ? l + 16'd1 : l;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_word_char(logic [7:0] c);
			return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || is_digit(c) || c == "_";
		endfunction

		// Words are packed right-justified so that they compare directly with literals.
		function token_class_t word_class();
			logic [111:0] w;
			if (word_ovf || open_len > 16'd14) begin
				return CLS_VARIABLE;
			end
			w = '0;
			for (int j = 0; j < int'(open_len); j++) begin
				w = {w[103:0], word_buf[j]};
			end
			case (w)
				"IDENTIFICATION", "DIVISION", "PROGRAM", "ENVIRONMENT", "SELECT",
				"ASSIGN", "FD", "SD", "FILE", "DATA", "SECTION", "PROCEDURE",
				"DECLARATIVES", "IF", "THEN", "ELSE", "ENDIF", "PERFORM", "VARYING",
				"FROM", "TO", "BY", "TIMES", "WHILE", "GO", "MOVE", "ADD", "SUBTRACT",
				"MULTIPLY", "DIVIDE", "COMPUTE", "SET", "RESET", "ACCEPT", "DISPLAY",
				"CALL", "RETURN", "STOP", "END", "TRUE", "FALSE", "ZERO", "SPACE",
				"NULL": return CLS_KEYWORD;
				default: return CLS_VARIABLE;
			endcase
		endfunction

		// Class of the open token when it ends without taking the byte.
		function token_class_t open_class();
			case (open_kind)
				PK_STRING:  return CLS_STRING;
				PK_COMMENT: return CLS_COMMENT;
				PK_NUMBER:  return CLS_NUMBER;
				PK_WORD:    return word_class();
				PK_EQ:      return CLS_VARIABLE;
				default:    return CLS_OPERATOR;
			endcase
		endfunction

		function void open_token(pend_kind_t k, logic [23:0] p);
			open_kind  = k;
			open_start = p;
			open_len   = 16'd1;
		endfunction

		// A byte that arrives with no token open.
		function void start_token(logic [7:0] c, logic [23:0] p);
			case (c)
				" ":  emit_token(CLS_SPACE, p, 16'd1);
				"\n": emit_token(CLS_NEWLINE, p, 16'd1);
				"\t": emit_token(CLS_TAB, p, 16'd1);
				"\"", "'": begin
					open_token(PK_STRING, p);
					quote_single = (c == "'");
				end
				"*", "/": open_token(PK_COMMENT, p);
				"{", "}", "[", "]", "(", ")": emit_token(CLS_BRACKET, p, 16'd1);
				"=": open_token(PK_EQ, p);
				"+": open_token(PK_PLUS, p);
				"-": open_token(PK_MINUS, p);
				"<", ">", "&", "|", "^", "~", "!": emit_token(CLS_OPERATOR, p, 16'd1);
				default: begin
					if (is_digit(c)) begin
						open_token(PK_NUMBER, p);
					end else if (is_word_char(c)) begin
						open_token(PK_WORD, p);
						word_buf[0] = c;
						word_ovf    = 1'b0;
					end else begin
						emit_token(CLS_VARIABLE, p, 16'd1);
					end
				end
			endcase
		endfunction

		// Notes one accepted input transfer and queues the tokens it finishes.
		function void take_byte(logic [7:0] c, logic eot);
			logic [23:0] p;
			bit          restart;
			new_tokens.delete();
			if (eot) begin
				if (open_kind != PK_NONE) begin
					emit_token(open_class(), open_start, open_len);
				end
				open_kind = PK_NONE;
				position  = '0;
			end else begin
				p        = position;
				position = p + 24'd1;
				restart  = 1'b1;
				case (open_kind)
					PK_STRING: begin
						open_len = grown(open_len);
						if (c == (quote_single ? "'" : "\"")) begin
							emit_token(CLS_STRING, open_start, open_len);
							open_kind = PK_NONE;
						end
						restart = 1'b0;
					end
					PK_COMMENT: begin
						if (c != "\n") begin
							open_len = grown(open_len);
							restart  = 1'b0;
						end
					end
					PK_NUMBER: begin
						if (is_digit(c) || c == ".") begin
							open_len = grown(open_len);
							restart  = 1'b0;
						end
					end
					PK_WORD: begin
						if (is_word_char(c)) begin
							if (open_len < 16'd14) begin
								word_buf[int'(open_len)] = c;
							end else begin
								word_ovf = 1'b1;
							end
							open_len = grown(open_len);
							restart  = 1'b0;
						end
					end
					PK_EQ, PK_PLUS, PK_MINUS: begin
						if (c == "=") begin
							emit_token(CLS_OPERATOR, open_start, grown(open_len));
							open_kind = PK_NONE;
							restart   = 1'b0;
						end
					end
					default: ;
				endcase
				if (restart) begin
					if (open_kind != PK_NONE) begin
						emit_token(open_class(), open_start, open_len);
					end
					open_kind = PK_NONE;
					start_token(c, p);
				end
			end
			if (new_tokens.size() > 0) begin
				new_tokens[new_tokens.size()-1].last = 1'b1;
			end
			foreach (new_tokens[i]) awaited.push_back(new_tokens[i]);
		endfunction

		// Compares one token transfer with the oldest expectation.
		function void match_token(logic [3:0] cls, logic [23:0] s, logic [15:0] l,
				logic last);
			lex_token_t e;
			bit         bad;
			if (awaited.size() == 0) begin
				$error("unexpected token: class %0d start %0d length %0d", cls, s, l);
				failures++;
				return;
			end
			e   = awaited.pop_front();
			bad = 1'b0;
			if (cls !== e.cls) begin
				$error("token_class: expected %0d, got %0d", e.cls, cls);
				bad = 1'b1;
			end
			if (s !== e.start) begin
				$error("token_start: expected %0d, got %0d", e.start, s);
				bad = 1'b1;
			end
			if (l !== e.len) begin
				$error("token_length: expected %0d, got %0d", e.len, l);
				bad = 1'b1;
			end
			if (last !== e.last) begin
				$error("last_of_run: expected %0d, got %0d", e.last, last);
				bad = 1'b1;
			end
			if (bad) failures++;
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic [7:0]              ch;
	logic                    end_of_text;
	logic                    empty;
	logic                    pop;
	logic [CLASS_W-1:0]      token_class;
	logic [START_W-1:0]      token_start;
	logic [LENGTH_OUT_W-1:0] token_length;
	logic                    last_of_run;

	token_scoreboard sb;
	bit              tx_idle_on = 1'b0;
	bit              rx_idle_on = 1'b1;
	bit              popped     = 1'b0;
	int unsigned     bytes_sent = 0;

	cobol_highlight_lexer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.ch           (ch),
		.end_of_text  (end_of_text),
		.empty        (empty),
		.pop          (pop),
		.token_class  (token_class),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap(bit enabled);
		int unsigned r;
		if (!enabled) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// One input transfer, after an optional idle gap.
	task automatic send_item(input logic [7:0] c, input logic eot);
		int unsigned gap;
		gap = pick_gap(tx_idle_on);
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push        = 1'b1;
		ch          = c;
		end_of_text = eot;
		do @(posedge clk); while (full);
		sb.take_byte(c, eot);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	task automatic send_eot();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] word_char(bit lead);
		string alphabet;
		alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
		return alphabet[$urandom_range(0, lead ? 52 : 62)];
	endfunction

	function automatic string pick_keyword();
		case ($urandom_range(0, 45))
			0: return "IDENTIFICATION"; 1: return "DIVISION"; 2: return "PROGRAM";
			3: return "ENVIRONMENT"; 4: return "SELECT"; 5: return "ASSIGN";
			6: return "FD"; 7: return "SD"; 8: return "FILE"; 9: return "DATA";
			10: return "SECTION"; 11: return "PROCEDURE"; 12: return "DECLARATIVES";
			13: return "IF"; 14: return "THEN"; 15: return "ELSE"; 16: return "ENDIF";
			17: return "PERFORM"; 18: return "VARYING"; 19: return "FROM";
			20: return "TO"; 21: return "BY"; 22: return "TIMES"; 23: return "WHILE";
			24: return "GO"; 25: return "MOVE"; 26: return "ADD"; 27: return "SUBTRACT";
			28: return "MULTIPLY"; 29: return "DIVIDE"; 30: return "COMPUTE";
			31: return "SET"; 32: return "RESET"; 33: return "ACCEPT";
			34: return "DISPLAY"; 35: return "CALL"; 36: return "RETURN";
			37: return "STOP"; 38: return "END"; 39: return "TRUE"; 40: return "FALSE";
			41: return "ZERO"; 42: return "SPACE"; 43: return "NULL";
			44: return "END-IF";
			default: return "WORKING-STORAGE";
		endcase
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(32, 126));
	endfunction

	// One random token of source text, mostly well formed.
	task automatic send_random_token();
		string       s;
		int unsigned r;
		int unsigned n;
		logic [7:0]  q;
		logic [7:0]  c;
		r = $urandom_range(0, 99);
		s = "";
		if (r < 20) begin
			// Keyword, sometimes altered into a near miss.
			s = pick_keyword();
			case ($urandom_range(0, 9))
				0: s[0] = s[0] | 8'h20;
				1: s = s.substr(0, s.len() - 2);
				2: s = {s, string'(word_char(1'b0))};
				default: ;
			endcase
			if ($urandom_range(0, 9) < 7) s = {s, " "};
			send_text(s);
		end else if (r < 35) begin
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
			s = string'(word_char(1'b1));
			repeat (n - 1) s = {s, string'(word_char(1'b0))};
			if ($urandom_range(0, 9) < 7) s = {s, " "};
			send_text(s);
		end else if (r < 45) begin
			s = string'(8'("0" + $urandom_range(0, 9)));
			repeat ($urandom_range(0, 5)) begin
				s = {s, ($urandom_range(0, 4) == 0) ? "." : string'(8'("0" + $urandom_range(0, 9)))};
			end
			send_text(s);
		end else if (r < 53) begin
			q = $urandom_range(0, 1) ? "'" : "\"";
			s = string'(q);
			repeat ($urandom_range(0, 8)) begin
				c = ($urandom_range(0, 7) == 0) ? "\n" : printable();
				if (c == q) c = "x";
				s = {s, string'(c)};
			end
			send_text(s);
			if ($urandom_range(0, 9) == 0) begin
				send_eot();
			end else begin
				send_item(q, 1'b0);
			end
		end else if (r < 60) begin
			s = $urandom_range(0, 1) ? "*" : "/";
			repeat ($urandom_range(0, 10)) begin
				c = printable();
				s = {s, string'(c)};
			end
			send_text(s);
			if ($urandom_range(0, 6) == 0) send_eot();
			else send_item("\n", 1'b0);
		end else if (r < 72) begin
			case ($urandom_range(0, 14))
				0: s = "=="; 1: s = "+="; 2: s = "-="; 3: s = "="; 4: s = "+";
				5: s = "-"; 6: s = "<"; 7: s = ">"; 8: s = "&"; 9: s = "|";
				10: s = "^"; 11: s = "~"; 12: s = "!"; 13: s = "*=";
				default: s = "/=";
			endcase
			send_text(s);
		end else if (r < 85) begin
			case ($urandom_range(0, 2))
				0: send_item(" ", 1'b0);
				1: send_item("\n", 1'b0);
				default: send_item("\t", 1'b0);
			endcase
		end else if (r < 90) begin
			case ($urandom_range(0, 5))
				0: send_item("(", 1'b0); 1: send_item(")", 1'b0);
				2: send_item("[", 1'b0); 3: send_item("]", 1'b0);
				4: send_item("{", 1'b0); default: send_item("}", 1'b0);
			endcase
		end else if (r < 96) begin
			send_item(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_eot();
		end
	endtask

	// Result channel: check every token transfer.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			sb.match_token(token_class, token_start, token_length, last_of_run);
			popped = 1'b1;
		end
	end

	// Receiver stalls, with busy and quiet stretches.
	initial begin
		int unsigned hold;
		pop  = 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (popped) begin
				popped = 1'b0;
				if ($urandom_range(0, 49) == 0) rx_idle_on = !rx_idle_on;
				hold = pick_gap(rx_idle_on);
			end
			if (hold > 0) begin
				pop = 1'b0;
				hold--;
			end else begin
				pop = 1'b1;
			end
		end
	end

	// Main sequence.
	initial begin
		int unsigned random_base;
		sb          = new();
		arst_n      = 1'b0;
		push        = 1'b0;
		ch          = 8'h00;
		end_of_text = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every class, the lookahead operators and the flush cases.
		tx_idle_on = 1'b1;
		send_text("IF _b9==7.0+=");
		send_text("-\t{'\"'*\n");
		send_item(8'hFF, 1'b0);
		send_text("!/");
		send_eot();
		send_text("\"x");
		send_eot();
		send_eot();
		send_text("=");
		send_eot();

		// Long tokens: a word well past the keyword length and a long string.
		tx_idle_on = 1'b0;
		send_item("W", 1'b0);
		repeat (40) send_item(word_char(1'b0), 1'b0);
		send_item(" ", 1'b0);
		send_item("'", 1'b0);
		repeat (40) send_item(printable() == "'" ? "a" : "b", 1'b0);
		send_item("'", 1'b0);
		send_eot();

		// Random text in short sentences, idling switched per sentence.
		random_base = bytes_sent;
		while (bytes_sent - random_base < 1000) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 12)) send_random_token();
		end
		send_eot();
		@(negedge clk);
		push = 1'b0;

		// Drain, then allow for the lexer's latency before the verdict.
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#25_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
sv/clhl_pkg.sv
sv/clhl_front.sv
sv/clhl_queue.sv
sv/clhl_back.sv
sv/cobol_highlight_lexer_top.sv
sv/clhl_checker.sv
sim/tb_cobol_highlight_lexer_top.sv
